@@ rtl/per_user_event_count_table_defines.svh @@
// Assertion macros for the per-user event count table.
// No dependencies; included by the files that assert.
`ifndef PER_USER_EVENT_COUNT_TABLE_DEFINES_SVH
`define PER_USER_EVENT_COUNT_TABLE_DEFINES_SVH

`ifndef ASSERT_OFF
`define UECT_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define UECT_ASSERT_SEQ(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define UECT_ASSERT(lbl, clk, rst_n, prop, msg)
`define UECT_ASSERT_SEQ(lbl, clk, rst_n, pre, post, msg)
`endif

`endif

@@ rtl/uect_pkg.sv @@
// Types and constants for the per-user event count table.
// No dependencies.
package uect_pkg;

	localparam int unsigned SLOT_W = 4;
	localparam logic [31:0] INVALID_USER = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [31:0] user_id;
		logic [31:0] now_seconds;
	} evt_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic [31:0]       event_count;
		logic              new_user;
		logic              table_full;
	} res_t;

	typedef struct packed {
		logic [31:0] user;
		logic [31:0] count;
		logic [31:0] first_seen;
		logic [31:0] last_seen;
	} row_t;

endpackage

@@ rtl/uect_ram.sv @@
// Slot table storage: one write port, one read port, registered read data.
// Depends on uect_pkg.
module uect_ram #(
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  uect_pkg::row_t                             wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output uect_pkg::row_t                             rdata
);

	uect_pkg::row_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/per_user_event_count_table.sv @@
// Per-user event count table: slot 0 in registers, slots 1.. in uect_ram.
// Slot 0 items update registers directly; other items search slots 1 to next_free - 1 over the one RAM read port.
// A new item is taken only in idle, once the last item's result has moved into the result register.
// The result register lets the next item enter while a result waits.
// Reset (arst_n low, async): next_free = 1, slot 0 count and times zero, no result pending.
// Depends on uect_pkg, uect_ram and per_user_event_count_table_defines.svh.
`include "per_user_event_count_table_defines.svh"

module per_user_event_count_table #(
	parameter int ENTRIES = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            evt_valid,
	output logic            evt_ready,
	input  uect_pkg::evt_t  evt,
	output logic            res_valid,
	input  logic            res_ready,
	output uect_pkg::res_t  res
);

	localparam int AW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int NFW = $clog2(ENTRIES + 1);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SEARCH = 2'd1;
	localparam logic [1:0] ST_OUT    = 2'd2;

	logic [1:0]     state_q;
	logic [NFW-1:0] nf_q;
	logic [NFW-1:0] idx_q;
	logic [AW-1:0]  pidx_s1;
	logic           pend_s1;
	logic [31:0]    user_q;
	logic [31:0]    now_q;
	logic [31:0]    count0_q;
	logic [31:0]    first0_q;
	logic [31:0]    last0_q;
	uect_pkg::res_t done_q;
	uect_pkg::res_t res_q;
	logic           res_valid_q;

	logic           full;
	logic           to_slot0;
	logic           issue;
	logic           hit;
	logic           miss;
	logic           ram_we;
	logic [AW-1:0]  ram_waddr;
	uect_pkg::row_t ram_wdata;
	uect_pkg::row_t rd_row;
	logic [31:0]    hit_count;
	logic           load_res;

	assign full      = nf_q >= NFW'(ENTRIES);
	assign to_slot0  = full || (evt.user_id == uect_pkg::INVALID_USER);
	assign hit       = pend_s1 && (rd_row.user == user_q);
	assign issue     = (state_q == ST_SEARCH) && (idx_q < nf_q) && !hit;
	assign miss      = (state_q == ST_SEARCH) && !pend_s1 && !(idx_q < nf_q);
	assign hit_count = rd_row.count + 32'd1;
	assign evt_ready = (state_q == ST_IDLE);
	assign load_res  = (state_q == ST_OUT) && (!res_valid_q || res_ready);

	always_comb begin
		ram_we    = (state_q == ST_SEARCH) && (hit || miss);
		ram_waddr = hit ? pidx_s1 : nf_q[AW-1:0];
		ram_wdata.user = user_q;
		if (hit) begin
			ram_wdata.count      = hit_count;
			ram_wdata.first_seen = rd_row.first_seen;
		end else begin
			ram_wdata.count      = 32'd1;
			ram_wdata.first_seen = now_q;
		end
		ram_wdata.last_seen = now_q;
	end

	uect_ram #(
		.DEPTH(ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (issue),
		.raddr (idx_q[AW-1:0]),
		.rdata (rd_row)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			nf_q     <= NFW'(1);
			idx_q    <= NFW'(1);
			pend_s1  <= 1'b0;
			count0_q <= '0;
			first0_q <= '0;
			last0_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (evt_valid) begin
						user_q <= evt.user_id;
						now_q  <= evt.now_seconds;
						if (to_slot0) begin
							count0_q <= count0_q + 32'd1;
							last0_q  <= evt.now_seconds;
							if (first0_q == 32'd0) begin
								first0_q <= evt.now_seconds;
							end
							done_q.slot        <= '0;
							done_q.event_count <= count0_q + 32'd1;
							done_q.new_user    <= 1'b0;
							done_q.table_full  <= full;
							state_q <= ST_OUT;
						end else begin
							idx_q   <= NFW'(1);
							pend_s1 <= 1'b0;
							state_q <= ST_SEARCH;
						end
					end
				end
				ST_SEARCH: begin
					pend_s1 <= issue;
					pidx_s1 <= idx_q[AW-1:0];
					if (issue) begin
						idx_q <= idx_q + NFW'(1);
					end
					if (hit) begin
						done_q.slot        <= uect_pkg::SLOT_W'(pidx_s1);
						done_q.event_count <= hit_count;
						done_q.new_user    <= 1'b0;
						done_q.table_full  <= 1'b0;
						state_q <= ST_OUT;
					end else if (miss) begin
						done_q.slot        <= uect_pkg::SLOT_W'(nf_q);
						done_q.event_count <= 32'd1;
						done_q.new_user    <= 1'b1;
						done_q.table_full  <= 1'b0;
						nf_q    <= nf_q + NFW'(1);
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (load_res) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_res) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			res_q <= done_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	`UECT_ASSERT(a_nf_range, clk, arst_n, (nf_q >= NFW'(1)) && (nf_q <= NFW'(ENTRIES)), "next_free out of range")
	`UECT_ASSERT(a_nf_step, clk, arst_n, $stable(nf_q) || (nf_q == $past(nf_q) + NFW'(1)), "next_free moved by other than one")
	`UECT_ASSERT(a_read_below_nf, clk, arst_n, !issue || (idx_q < nf_q), "lookup read of a free slot")
	`UECT_ASSERT_SEQ(a_busy_after_accept, clk, arst_n, evt_valid && evt_ready, state_q != ST_IDLE, "accepted item left no work")

endmodule
